[hdl/sbsyuv_pkg.sv]
package sbsyuv_pkg;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int GEOM_W     = 14;
    localparam int SAMPLE_W   = 8;
    localparam int ACC_W      = 20;
    localparam int DIFF_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_EYE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] EYE_WIDTH_RESET  = 13'd1280;
    localparam logic [CFG_DATA_W-1:0] EYE_HEIGHT_RESET = 13'd720;

    localparam logic signed [DIFF_W-1:0] LUMA_OFFSET   = 10'sd16;
    localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 10'sd128;

    localparam logic signed [ACC_W-1:0] COEF_Y     = 20'sd298;
    localparam logic signed [ACC_W-1:0] COEF_U_B   = 20'sd516;
    localparam logic signed [ACC_W-1:0] COEF_U_G   = 20'sd100;
    localparam logic signed [ACC_W-1:0] COEF_V_G   = 20'sd208;
    localparam logic signed [ACC_W-1:0] COEF_V_R   = 20'sd409;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 20'sd128;

    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic        eye_select;
        logic [11:0] pixel_x;
        logic [11:0] pixel_row;
        logic        line_end;
        logic        frame_end;
    } pos_tag_t;

endpackage

[hdl/sbsyuv_pixel_convert.sv]
module sbsyuv_pixel_convert (
    input  logic [7:0] luma,
    input  logic [7:0] chroma_blue,
    input  logic [7:0] chroma_red,
    output logic [7:0] blue,
    output logic [7:0] green,
    output logic [7:0] red
);
    import sbsyuv_pkg::*;

    logic signed [DIFF_W-1:0] c_val;
    logic signed [DIFF_W-1:0] d_val;
    logic signed [DIFF_W-1:0] e_val;
    logic signed [ACC_W-1:0]  c_ext;
    logic signed [ACC_W-1:0]  d_ext;
    logic signed [ACC_W-1:0]  e_ext;
    logic signed [ACC_W-1:0]  luma_term;
    logic signed [ACC_W-1:0]  acc_blue;
    logic signed [ACC_W-1:0]  acc_green;
    logic signed [ACC_W-1:0]  acc_red;

    function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-9:0] quo;
        begin
            quo = acc[ACC_W-1:8];
            if (quo[ACC_W-9])
                clamp_channel = 8'd0;
            else if (|quo[ACC_W-10:8])
                clamp_channel = 8'd255;
            else
                clamp_channel = quo[7:0];
        end
    endfunction

    always_comb
    begin
        c_val     = $signed({2'b00, luma}) - LUMA_OFFSET;
        d_val     = $signed({2'b00, chroma_blue}) - CHROMA_OFFSET;
        e_val     = $signed({2'b00, chroma_red}) - CHROMA_OFFSET;
        c_ext     = $signed({{(ACC_W-DIFF_W){c_val[DIFF_W-1]}}, c_val});
        d_ext     = $signed({{(ACC_W-DIFF_W){d_val[DIFF_W-1]}}, d_val});
        e_ext     = $signed({{(ACC_W-DIFF_W){e_val[DIFF_W-1]}}, e_val});
        luma_term = c_ext * COEF_Y;
        acc_blue  = luma_term + d_ext * COEF_U_B + ROUND_BIAS;
        acc_green = luma_term - d_ext * COEF_U_G - e_ext * COEF_V_G + ROUND_BIAS;
        acc_red   = luma_term + e_ext * COEF_V_R + ROUND_BIAS;
        blue      = clamp_channel(acc_blue);
        green     = clamp_channel(acc_green);
        red       = clamp_channel(acc_red);
    end

endmodule

[hdl/sbsyuv_position.sv]
module sbsyuv_position #(
    parameter int MAX_EYE_WIDTH  = 4096,
    parameter int MAX_EYE_HEIGHT = 4096
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write,
    input  logic [sbsyuv_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [sbsyuv_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic                                         advance,
    output sbsyuv_pkg::pos_tag_t                         tag
);
    import sbsyuv_pkg::*;

    localparam int COL_W = $clog2(MAX_EYE_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_EYE_HEIGHT + 1);
    localparam logic [GEOM_W-1:0] W_LIMIT = GEOM_W'(MAX_EYE_WIDTH - (MAX_EYE_WIDTH % 2));
    localparam logic [GEOM_W-1:0] H_LIMIT = GEOM_W'(MAX_EYE_HEIGHT);

    logic [CFG_DATA_W-1:0] eye_width_reg;
    logic [CFG_DATA_W-1:0] eye_height_reg;
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;

    logic [GEOM_W-1:0] w_even;
    logic [GEOM_W-1:0] w_eff;
    logic [GEOM_W-1:0] h_raw;
    logic [GEOM_W-1:0] h_eff;
    logic [GEOM_W-1:0] half;
    logic [GEOM_W-1:0] col_ext;
    logic [GEOM_W-1:0] row_ext;
    logic [GEOM_W-1:0] x_macro;
    logic              right_eye;
    logic              last_col;
    logic              last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_width_reg  <= EYE_WIDTH_RESET;
            eye_height_reg <= EYE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EYE_WIDTH:  eye_width_reg  <= cfg_data;
                CFG_EYE_HEIGHT: eye_height_reg <= cfg_data;
                default:        eye_width_reg  <= eye_width_reg;
            endcase
        end
    end

    always_comb
    begin
        w_even = {1'b0, eye_width_reg[CFG_DATA_W-1:1], 1'b0};
        if (w_even < GEOM_W'(2))
            w_eff = GEOM_W'(2);
        else if (w_even > W_LIMIT)
            w_eff = W_LIMIT;
        else
            w_eff = w_even;

        h_raw = {1'b0, eye_height_reg};
        if (h_raw < GEOM_W'(1))
            h_eff = GEOM_W'(1);
        else if (h_raw > H_LIMIT)
            h_eff = H_LIMIT;
        else
            h_eff = h_raw;

        half      = w_eff >> 1;
        col_ext   = GEOM_W'(col_reg);
        row_ext   = GEOM_W'(row_reg);
        right_eye = col_ext >= half;
        x_macro   = right_eye ? (col_ext - half) : col_ext;
        last_col  = (col_ext + GEOM_W'(1)) >= w_eff;
        last_row  = (row_ext + GEOM_W'(1)) >= h_eff;

        tag.eye_select = right_eye;
        tag.pixel_x    = {x_macro[10:0], 1'b0};
        tag.pixel_row  = row_ext[11:0];
        tag.line_end   = last_col;
        tag.frame_end  = last_col && last_row;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[hdl/stereo_yuyv_to_bgra_splitter_unit.sv]
// Side-by-side stereo YUYV to BGRA converter. Each request carries one
// macropixel (Y0, U, Y1, V) in raster order over the full double-width row;
// the result carries two BT.601 BGRA pixels plus the eye, x, row, line end
// and frame end of that macropixel. One request is taken every clock cycle
// while in_stall is low; it goes via the input register and the conversion
// logic into the result register. The user must write eye_width and
// eye_height via cfg port only while no request is in flight; not enforced.
module stereo_yuyv_to_bgra_splitter_unit #(
    parameter int MAX_EYE_WIDTH  = 4096,
    parameter int MAX_EYE_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sbsyuv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbsyuv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        luma_first,
    input  logic [7:0]                        chroma_blue,
    input  logic [7:0]                        luma_second,
    input  logic [7:0]                        chroma_red,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              eye_select,
    output logic [11:0]                       pixel_x,
    output logic [11:0]                       pixel_row,
    output logic [7:0]                        blue_first,
    output logic [7:0]                        green_first,
    output logic [7:0]                        red_first,
    output logic [7:0]                        blue_second,
    output logic [7:0]                        green_second,
    output logic [7:0]                        red_second,
    output logic [7:0]                        alpha_level,
    output logic                              line_end,
    output logic                              frame_end
);
    import sbsyuv_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     s1_advance;
    logic     in_accept;

    logic [7:0] luma_first_reg;
    logic [7:0] chroma_blue_reg;
    logic [7:0] luma_second_reg;
    logic [7:0] chroma_red_reg;
    pos_tag_t   cur_tag;
    pos_tag_t   s1_tag_reg;
    pos_tag_t   out_tag_reg;

    logic [7:0] blue0;
    logic [7:0] green0;
    logic [7:0] red0;
    logic [7:0] blue1;
    logic [7:0] green1;
    logic [7:0] red1;

    logic [7:0] blue_first_reg;
    logic [7:0] green_first_reg;
    logic [7:0] red_first_reg;
    logic [7:0] blue_second_reg;
    logic [7:0] green_second_reg;
    logic [7:0] red_second_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && out_stall);
    end

    sbsyuv_position #(
        .MAX_EYE_WIDTH  (MAX_EYE_WIDTH),
        .MAX_EYE_HEIGHT (MAX_EYE_HEIGHT)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .tag       (cur_tag)
    );

    sbsyuv_pixel_convert u_convert_first (
        .luma        (luma_first_reg),
        .chroma_blue (chroma_blue_reg),
        .chroma_red  (chroma_red_reg),
        .blue        (blue0),
        .green       (green0),
        .red         (red0)
    );

    sbsyuv_pixel_convert u_convert_second (
        .luma        (luma_second_reg),
        .chroma_blue (chroma_blue_reg),
        .chroma_red  (chroma_red_reg),
        .blue        (blue1),
        .green       (green1),
        .red         (red1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture request
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            luma_first_reg  <= luma_first;
            chroma_blue_reg <= chroma_blue;
            luma_second_reg <= luma_second;
            chroma_red_reg  <= chroma_red;
            s1_tag_reg      <= cur_tag;
        end
    end

    // advance converted result
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            blue_first_reg   <= blue0;
            green_first_reg  <= green0;
            red_first_reg    <= red0;
            blue_second_reg  <= blue1;
            green_second_reg <= green1;
            red_second_reg   <= red1;
            out_tag_reg      <= s1_tag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign eye_select   = out_tag_reg.eye_select;
    assign pixel_x      = out_tag_reg.pixel_x;
    assign pixel_row    = out_tag_reg.pixel_row;
    assign line_end     = out_tag_reg.line_end;
    assign frame_end    = out_tag_reg.frame_end;
    assign blue_first   = blue_first_reg;
    assign green_first  = green_first_reg;
    assign red_first    = red_first_reg;
    assign blue_second  = blue_second_reg;
    assign green_second = green_second_reg;
    assign red_second   = red_second_reg;
    assign alpha_level  = ALPHA_OPAQUE;

`ifndef ASSERT_OFF
    a_frame_end_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_tag_reg.frame_end || out_tag_reg.line_end))
        else $error("frame end without line end");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced request lost before output");

    a_pixel_x_even: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !s1_tag_reg.pixel_x[0])
        else $error("odd pixel x captured");
`endif

endmodule
